[hw/rtl/soldering_station_controller_defines.svh]
// Assertion macros used by the checker of the soldering station controller.
`ifndef SOLDERING_STATION_CONTROLLER_DEFINES_SVH
`define SOLDERING_STATION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define SSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc implication check failed");

// Next-cycle implication, ignored while reset is held.
`define SSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define SSC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssc reset check failed");

`endif

[hw/rtl/ssc_pkg.sv]
// Types, constants and helper functions of the soldering station controller.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int TIMER_W    = 12;
  localparam int SP_W       = 6;
  localparam int CODE_W     = 4;
  localparam int MEAS_W     = 7;
  localparam int LED_W      = 8;
  localparam int DISP_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_SETPOINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET    = 2'd1;

  localparam logic [SP_W-1:0] SET_MIN      = 6'd31;
  localparam logic [SP_W-1:0] SET_MAX      = 6'd41;
  localparam logic [SP_W-1:0] START_RESET  = 6'd35;
  localparam logic [SP_W-1:0] OFFSET_RESET = 6'd28;

  localparam logic [LED_W-1:0] LED_POWER   = 8'h80;
  localparam logic [LED_W-1:0] LED_HEAT    = 8'h40;
  localparam logic [LED_W-1:0] LED_DISPLAY = 8'h3F;
  localparam logic [LED_W-1:0] LED_TOP     = 8'hC0;

  typedef enum logic [2:0] {
    MODE_OFF = 3'b001,
    MODE_ON  = 3'b010,
    MODE_ERR = 3'b100
  } mode_t;

  typedef struct packed {
    logic              power_switch;
    logic [CODE_W-1:0] temp_gray;
    logic              button_up_level;
    logic              button_down_level;
  } in_item_t;

  typedef struct packed {
    logic              power_led;
    logic              heater_on;
    logic [DISP_W-1:0] display_leds;
  } out_item_t;

  typedef struct packed {
    logic [SP_W-1:0] start_setpoint;
    logic [SP_W-1:0] temp_offset;
  } cfg_t;

  // Binary value of a reflected Gray code.
  function automatic logic [CODE_W-1:0] gray_to_code(input logic [CODE_W-1:0] g);
    logic [CODE_W-1:0] b;
    b[3] = g[3];
    b[2] = g[3] ^ g[2];
    b[1] = g[3] ^ g[2] ^ g[1];
    b[0] = g[3] ^ g[2] ^ g[1] ^ g[0];
    return b;
  endfunction

  // Display pattern for a setpoint; values outside the range use the end entries.
  function automatic logic [DISP_W-1:0] pattern_for(input logic [SP_W-1:0] sp);
    logic [SP_W-1:0]   idx;
    logic [DISP_W-1:0] pat;
    idx = (sp < SET_MIN) ? '0 : sp - SET_MIN;
    case (idx)
      6'd0:    pat = 6'd1;
      6'd1:    pat = 6'd3;
      6'd2:    pat = 6'd2;
      6'd3:    pat = 6'd6;
      6'd4:    pat = 6'd4;
      6'd5:    pat = 6'd12;
      6'd6:    pat = 6'd8;
      6'd7:    pat = 6'd24;
      6'd8:    pat = 6'd16;
      6'd9:    pat = 6'd48;
      default: pat = 6'd32;
    endcase
    return pat;
  endfunction

endpackage

[hw/rtl/soldering_station_controller.sv]
// Top level of the soldering station controller: input stage, state update, output stage.
//
//  Channel | Ports            | Direction | Word
//  --------+------------------+-----------+------------------------------------------
//  in      | in_tvalid/tready | sink      | one tick: switch, sensor code, buttons
//  out     | out_tvalid/tready| source    | LED byte: power, heater, display
//  cfg     | cfg_valid/ready  | sink      | register index and write data
//
// Every accepted tick gives exactly one result word through the input register and then
// the output register; a new tick can be taken every cycle unless stalled. The state
// update sits in one combinational pass between them. Holding out_tready low stalls
// the output register and then the input register; in_tready drops only when both are
// full. Reset clears the controller state and loads the register defaults.
`timescale 1ns / 1ps

module soldering_station_controller #(
  parameter int BLINK_PERIOD_MS = 2000,
  parameter int TICK_MS         = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] power_switch, [4:1] temp_gray, [5] button_up_level, [6] button_down_level
  input  logic [ssc_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] power_led, [1] heater_on, [7:2] display_leds
  output logic [ssc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic               s1_valid_r;
  ssc_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  ssc_pkg::out_item_t out_item_r;
  logic               s1_adv;
  logic               in_fire;
  logic               step;
  ssc_pkg::in_item_t  in_item;
  ssc_pkg::out_item_t res;
  ssc_pkg::cfg_t      cfg;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign step      = s1_valid_r && s1_adv;
  assign cfg_ready = 1'b1;

  assign in_item.power_switch      = in_tdata[0];
  assign in_item.temp_gray         = in_tdata[4:1];
  assign in_item.button_up_level   = in_tdata[5];
  assign in_item.button_down_level = in_tdata[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r  <= in_item;
    if (step)    out_item_r <= res;
  end

  ssc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ssc_core #(
    .BLINK_PERIOD_MS (BLINK_PERIOD_MS),
    .TICK_MS         (TICK_MS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_item_r.display_leds, out_item_r.heater_on, out_item_r.power_led};

endmodule

[hw/rtl/ssc_cfg.sv]
// Configuration registers: start setpoint and temperature offset.
`timescale 1ns / 1ps

module ssc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]   wr_data,
  output ssc_pkg::cfg_t                    cfg
);

  logic [ssc_pkg::SP_W-1:0] start_r;
  logic [ssc_pkg::SP_W-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= ssc_pkg::START_RESET;
      offset_r <= ssc_pkg::OFFSET_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ssc_pkg::CFG_START_SETPOINT: start_r  <= wr_data;
        ssc_pkg::CFG_TEMP_OFFSET:    offset_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.start_setpoint = start_r;
  assign cfg.temp_offset    = offset_r;

endmodule

[hw/rtl/ssc_core.sv]
// Controller state and the one-tick update of mode, setpoint, blink timer and LEDs.
`timescale 1ns / 1ps

module ssc_core #(
  parameter int BLINK_PERIOD_MS = 2000,
  parameter int TICK_MS         = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ssc_pkg::in_item_t  item,
  input  ssc_pkg::cfg_t      cfg,
  output ssc_pkg::out_item_t res
);

  localparam int TW       = ssc_pkg::TIMER_W;
  localparam int QUARTER  = BLINK_PERIOD_MS / 4;
  localparam int PHASE_W  = $clog2(QUARTER);
  localparam int PW1      = PHASE_W + 1;
  localparam logic [TW-1:0] PERIOD   = TW'(BLINK_PERIOD_MS);
  localparam logic [TW-1:0] HALF     = TW'(BLINK_PERIOD_MS / 2);
  localparam logic [TW:0]   TICK_EXT = (TW + 1)'(TICK_MS);
  localparam logic [PHASE_W-1:0] EIGHTH   = PHASE_W'(BLINK_PERIOD_MS / 8);
  localparam logic [PW1-1:0]     TICK_MOD = PW1'(TICK_MS % QUARTER);
  localparam logic [PW1-1:0]     QUART_C  = PW1'(QUARTER);

  ssc_pkg::mode_t                mode_r, mode_nxt, mode_cur;
  logic [ssc_pkg::SP_W-1:0]      sp_r, sp_nxt, sp_step, sp_start;
  logic [TW-1:0]                 timer_r, timer_nxt, timer_eff, timer_use;
  // Running remainder of the blink timer by a quarter period.
  logic [PHASE_W-1:0]            phase_r, phase_nxt, phase_eff, phase_use;
  logic                          fbe_r, fbe_nxt;
  logic [ssc_pkg::LED_W-1:0]     led_r, led_nxt;
  logic [1:0]                    prev_btn_r, prev_btn_nxt;

  logic [ssc_pkg::CODE_W-1:0]    code;
  logic [1:0]                    falling;
  logic [ssc_pkg::MEAS_W-1:0]    measured;
  logic [ssc_pkg::LED_W-1:0]     out_byte;
  logic                          wrap;
  logic                          clr;
  logic [TW:0]                   timer_sum;
  logic [PW1-1:0]                phase_sum;

  always_comb begin
    code         = ssc_pkg::gray_to_code(item.temp_gray);
    prev_btn_nxt = {item.button_down_level, item.button_up_level};
    falling      = prev_btn_r & ~prev_btn_nxt;
    measured     = {3'b000, code} + {1'b0, cfg.temp_offset};

    sp_start = cfg.start_setpoint;
    if (sp_start < ssc_pkg::SET_MIN) sp_start = ssc_pkg::SET_MIN;
    if (sp_start > ssc_pkg::SET_MAX) sp_start = ssc_pkg::SET_MAX;

    out_byte = led_r;
    mode_nxt = mode_r;
    sp_nxt   = sp_r;
    sp_step  = sp_r;
    fbe_nxt  = fbe_r;
    clr      = 1'b0;

    wrap      = timer_r > PERIOD;
    timer_eff = wrap ? '0 : timer_r;
    phase_eff = wrap ? '0 : phase_r;
    mode_cur  = item.power_switch ? mode_r : ssc_pkg::MODE_OFF;

    unique case (mode_cur)
      ssc_pkg::MODE_ERR: begin
        // Slow blink of the whole display while the sensor reports a fault.
        if (timer_eff > HALF) begin
          out_byte = out_byte & ~ssc_pkg::LED_DISPLAY;
        end else begin
          out_byte = out_byte | ssc_pkg::LED_DISPLAY;
        end
        if (code != '0) begin
          clr      = 1'b1;
          mode_nxt = ssc_pkg::MODE_ON;
        end
      end
      ssc_pkg::MODE_ON: begin
        // Up is applied before down when both buttons are released together.
        if (sp_step < ssc_pkg::SET_MAX && falling[0]) sp_step = sp_step + 6'd1;
        if (sp_step > ssc_pkg::SET_MIN && falling[1]) sp_step = sp_step - 6'd1;
        sp_nxt = sp_step;
        if ({1'b0, sp_step} == measured) begin
          fbe_nxt = 1'b0;
          clr     = 1'b1;
        end else begin
          fbe_nxt = 1'b1;
        end
        out_byte = (led_r & ssc_pkg::LED_TOP) | {2'b00, ssc_pkg::pattern_for(sp_step)};
        if ({1'b0, sp_step} > measured) begin
          out_byte = out_byte | ssc_pkg::LED_HEAT;
        end else begin
          out_byte = out_byte & ~ssc_pkg::LED_HEAT;
        end
        if (code == '0) begin
          fbe_nxt  = 1'b0;
          clr      = 1'b1;
          out_byte = out_byte & ~ssc_pkg::LED_HEAT;
          mode_nxt = ssc_pkg::MODE_ERR;
        end
      end
      default: begin
        out_byte = '0;
        mode_nxt = ssc_pkg::MODE_OFF;
        if (item.power_switch) begin
          sp_nxt   = sp_start;
          out_byte = ssc_pkg::LED_POWER;
          clr      = 1'b1;
          if (code != '0) begin
            mode_nxt = ssc_pkg::MODE_ON;
          end else begin
            fbe_nxt  = 1'b0;
            mode_nxt = ssc_pkg::MODE_ERR;
          end
        end
      end
    endcase

    timer_use = clr ? '0 : timer_eff;
    phase_use = clr ? '0 : phase_eff;

    // Fast blink: display dark in the upper part of each quarter period.
    if (phase_use > EIGHTH && fbe_nxt) begin
      out_byte = out_byte & ~ssc_pkg::LED_DISPLAY;
    end
    led_nxt = out_byte;

    timer_sum = {1'b0, timer_use} + TICK_EXT;
    timer_nxt = timer_sum[TW-1:0];
    phase_sum = {1'b0, phase_use} + TICK_MOD;
    if (phase_sum >= QUART_C) phase_sum = phase_sum - QUART_C;
    phase_nxt = phase_sum[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ssc_pkg::MODE_OFF;
      sp_r       <= '0;
      timer_r    <= '0;
      phase_r    <= '0;
      fbe_r      <= 1'b0;
      led_r      <= '0;
      prev_btn_r <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      sp_r       <= sp_nxt;
      timer_r    <= timer_nxt;
      phase_r    <= phase_nxt;
      fbe_r      <= fbe_nxt;
      led_r      <= led_nxt;
      prev_btn_r <= prev_btn_nxt;
    end
  end

  assign res.power_led    = out_byte[7];
  assign res.heater_on    = out_byte[6];
  assign res.display_leds = out_byte[ssc_pkg::DISP_W-1:0];

endmodule

[hw/rtl/ssc_checker.sv]
// Port-level checks of the soldering station controller and their bind.
`timescale 1ns / 1ps
`include "soldering_station_controller_defines.svh"

module ssc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ssc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // No result word may appear straight out of reset.
  `SSC_ASSERT_RST(a_no_out_after_reset, !rst_n, !out_tvalid)

  // A stalled result word holds.
  `SSC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // With the output side empty the input side always takes a word.
  `SSC_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready)

  // Heater and display are dark whenever the power LED is off.
  `SSC_ASSERT_IMP(a_dark_when_off, out_tvalid && !out_tdata[0], out_tdata[7:1] == 7'd0)

endmodule

bind soldering_station_controller ssc_checker u_ssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/soldering_station_controller_test.sv]
// Self-checking testbench of the soldering station controller with a tick-level LED predictor.
`timescale 1ns / 1ps

module soldering_station_controller_test;

  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 172;
  localparam int HOLD_LEN  = 300;

  localparam logic [ssc_pkg::SP_W-1:0] PHASE_START[PHASES] =
    '{6'd35, 6'd63, 6'd0, 6'd31, 6'd41, 6'd36};
  localparam logic [ssc_pkg::SP_W-1:0] PHASE_OFFSET[PHASES] =
    '{6'd28, 6'd0, 6'd63, 6'd28, 6'd30, 6'd25};
  localparam int TX_IDLE[PHASES]  = '{0, 46, 0, 30, 0, 30};
  localparam int RX_STALL[PHASES] = '{0, 0, 46, 30, 0, 30};

  // Predicts the LED byte of every tick and holds the words still to come.
  class led_scoreboard;
    localparam int BLINK_MS = 2000;
    localparam int STEP_MS  = 5;

    ssc_pkg::mode_t               mode;
    logic [ssc_pkg::SP_W-1:0]     setpoint;
    logic [11:0]                  blink_ms;
    logic                         fast_blink;
    logic [7:0]                   leds;
    logic [1:0]                   prev_btn;
    logic [ssc_pkg::SP_W-1:0]     start_sp;
    logic [ssc_pkg::SP_W-1:0]     offset;
    ssc_pkg::out_item_t           led_words_due[$];
    int                           errors;

    function new();
      mode       = ssc_pkg::MODE_OFF;
      setpoint   = '0;
      blink_ms   = '0;
      fast_blink = 1'b0;
      leds       = '0;
      prev_btn   = '0;
      start_sp   = ssc_pkg::START_RESET;
      offset     = ssc_pkg::OFFSET_RESET;
      errors     = 0;
    endfunction

    function void write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                            logic [ssc_pkg::CFG_DATA_W-1:0] val);
      if (idx == ssc_pkg::CFG_START_SETPOINT) start_sp = val;
      else if (idx == ssc_pkg::CFG_TEMP_OFFSET) offset = val;
    endfunction

    function void note_tick(logic pwr, logic [3:0] gray, logic up, logic dn);
      logic [3:0]         code;
      logic [1:0]         falling;
      int                 measured;
      int                 idx;
      logic [5:0]         pat;
      logic [7:0]         led;
      ssc_pkg::out_item_t e;
      code[3] = gray[3];
      for (int i = 2; i >= 0; i--) code[i] = code[i+1] ^ gray[i];
      falling  = prev_btn & ~{dn, up};
      prev_btn = {dn, up};
      measured = int'(code) + int'(offset);
      led      = leds;

      if (blink_ms > BLINK_MS) blink_ms = '0;
      if (!pwr) mode = ssc_pkg::MODE_OFF;

      case (mode)
        ssc_pkg::MODE_ERR: begin
          if (blink_ms > BLINK_MS / 2) led = led & ~ssc_pkg::LED_DISPLAY;
          else led = led | ssc_pkg::LED_DISPLAY;
          if (code != 0) begin
            blink_ms = '0;
            mode     = ssc_pkg::MODE_ON;
          end
        end
        ssc_pkg::MODE_ON: begin
          if (setpoint < ssc_pkg::SET_MAX && falling[0]) setpoint = setpoint + 1'b1;
          if (setpoint > ssc_pkg::SET_MIN && falling[1]) setpoint = setpoint - 1'b1;
          if (setpoint == measured) begin
            fast_blink = 1'b0;
            blink_ms   = '0;
          end else begin
            fast_blink = 1'b1;
          end
          // The pattern alternates single and double LEDs as the setpoint climbs.
          idx = (setpoint < ssc_pkg::SET_MIN) ? 0 : int'(setpoint - ssc_pkg::SET_MIN);
          if (idx > 10) idx = 10;
          pat = (idx % 2) ? (6'd3 << (idx / 2)) : (6'd1 << (idx / 2));
          led = (led & ssc_pkg::LED_TOP) | {2'b00, pat};
          if (setpoint > measured) led = led | ssc_pkg::LED_HEAT;
          else led = led & ~ssc_pkg::LED_HEAT;
          if (code == 0) begin
            fast_blink = 1'b0;
            blink_ms   = '0;
            led        = led & ~ssc_pkg::LED_HEAT;
            mode       = ssc_pkg::MODE_ERR;
          end
        end
        default: begin
          led  = '0;
          mode = ssc_pkg::MODE_OFF;
          if (pwr) begin
            setpoint = start_sp;
            if (setpoint < ssc_pkg::SET_MIN) setpoint = ssc_pkg::SET_MIN;
            if (setpoint > ssc_pkg::SET_MAX) setpoint = ssc_pkg::SET_MAX;
            led      = ssc_pkg::LED_POWER;
            blink_ms = '0;
            if (code != 0) begin
              mode = ssc_pkg::MODE_ON;
            end else begin
              fast_blink = 1'b0;
              mode       = ssc_pkg::MODE_ERR;
            end
          end
        end
      endcase

      if ((blink_ms % (BLINK_MS / 4)) > BLINK_MS / 8 && fast_blink) begin
        led = led & ~ssc_pkg::LED_DISPLAY;
      end
      leds     = led;
      blink_ms = 12'(blink_ms + STEP_MS);

      e.power_led    = led[7];
      e.heater_on    = led[6];
      e.display_leds = led[5:0];
      led_words_due.push_back(e);
    endfunction

    function void check_word(logic [ssc_pkg::OUT_DATA_W-1:0] w);
      ssc_pkg::out_item_t got;
      ssc_pkg::out_item_t e;
      got.power_led    = w[0];
      got.heater_on    = w[1];
      got.display_leds = w[7:2];
      if (led_words_due.size() == 0) begin
        $display("%0t: LED word %h arrived with none expected", $time, w);
        errors++;
        return;
      end
      e = led_words_due.pop_front();
      if (got.power_led !== e.power_led || got.heater_on !== e.heater_on ||
          got.display_leds !== e.display_leds) begin
        $display("%0t: LED expected power=%b heat=%b disp=%h actual power=%b heat=%b disp=%h",
                 $time, e.power_led, e.heater_on, e.display_leds,
                 got.power_led, got.heater_on, got.display_leds);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ssc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ssc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index = ssc_pkg::CFG_START_SETPOINT;
  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  led_scoreboard sb = new();

  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         off_left = 0;
  int         sensor_left = 0;
  logic [3:0] sensor_gray = '0;
  logic [1:0] btn = '0;

  soldering_station_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        sb.note_tick(in_tdata[0], in_tdata[4:1], in_tdata[5], in_tdata[6]);
      end
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  // A new hold request closes the output for a long stretch.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_tick(logic pwr, logic [3:0] gray, logic up, logic dn);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, dn, up, gray, pwr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly powered ticks with sensor values held for runs and button presses; some noise.
  task automatic draw_tick();
    logic pwr;
    if ($urandom_range(0, 99) < 8) begin
      send_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return;
    end
    if (off_left > 0) begin
      off_left--;
      pwr = 1'b0;
    end else begin
      pwr = 1'b1;
      if ($urandom_range(0, 99) == 0) off_left = $urandom_range(1, 4);
    end
    if (sensor_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        // Long faults let the slow blink reach its dark half, the longest through a whole period.
        sensor_gray = '0;
        sensor_left = ($urandom_range(0, 2) == 0) ? $urandom_range(210, 420) : $urandom_range(1, 6);
      end else begin
        sensor_gray = 4'($urandom_range(1, 15));
        sensor_left = $urandom_range(1, 80);
      end
    end
    sensor_left--;
    case ($urandom_range(0, 9))
      6: btn[0] = ~btn[0];
      7: btn[1] = ~btn[1];
      8: btn = 2'b11;
      9: btn = 2'b00;
      default: ;
    endcase
    send_tick(pwr, sensor_gray, btn[0], btn[1]);
  endtask

  task automatic write_reg(logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssc_pkg::CFG_DATA_W-1:0] val);
    while (sb.led_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b0, 4'h0, 1'b0, 1'b0);
    // Power on into a sensor fault, then recover.
    send_tick(1'b1, 4'h0, 1'b1, 1'b1);
    send_tick(1'b1, 4'h0, 1'b0, 1'b0);
    send_tick(1'b1, 4'hF, 1'b0, 1'b0);
    // Press up until the setpoint reaches the top of the range.
    repeat (6) begin
      send_tick(1'b1, 4'h8, 1'b1, 1'b0);
      send_tick(1'b1, 4'h8, 1'b0, 1'b0);
    end
    // Both buttons released together, then a reading equal to the setpoint.
    send_tick(1'b1, 4'h8, 1'b1, 1'b1);
    send_tick(1'b1, 4'h8, 1'b0, 1'b0);
    send_tick(1'b1, 4'hA, 1'b0, 1'b0);
    send_tick(1'b1, 4'h0, 1'b0, 1'b0);
    send_tick(1'b0, 4'hF, 1'b1, 1'b1);
    send_tick(1'b0, 4'hF, 1'b0, 1'b0);
    send_tick(1'b1, 4'h5, 1'b1, 1'b1);
    send_tick(1'b1, 4'h5, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      if (p > 0) begin
        write_reg(ssc_pkg::CFG_START_SETPOINT, PHASE_START[p]);
        write_reg(ssc_pkg::CFG_TEMP_OFFSET, PHASE_OFFSET[p]);
      end
      tx_idle_pct  = TX_IDLE[p];
      rx_stall_pct = RX_STALL[p];
      if (p == 4) hold_req++;
      off_left = 2;
      repeat (PHASE_LEN) draw_tick();
    end
    in_tvalid <= 1'b0;

    while (sb.led_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
